// File: design/ecf_pkg.sv
`timescale 1ns / 1ps
package ecf_pkg;

	localparam int NODES   = 64;
	localparam int EDGES   = 1024;
	localparam int NODE_W  = 6;
	localparam int CNT_W   = 11;
	localparam int EC_AW   = 2 * NODE_W;
	localparam int BAL_W   = CNT_W + 1;
	localparam int STK_DEPTH = EDGES + 1;
	localparam int STK_AW  = $clog2(STK_DEPTH);

	typedef enum logic [2:0] {
		CMD_START  = 3'd0,
		CMD_NEXT   = 3'd1,
		CMD_FINISH = 3'd2,
		CMD_READ   = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOCIRC = 2'd1,
		ST_OVER   = 2'd2,
		ST_ORDER  = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]        command;
		logic [NODE_W-1:0] stop_node;
	} in_item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [CNT_W-1:0]  edge_count;
		logic [NODE_W-1:0] circuit_node;
		logic              last;
	} out_item_t;

endpackage

// File: design/ecf_ram.sv
`timescale 1ns / 1ps
module ecf_ram #(
	parameter int W = 6,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: design/eulerian_circuit_finder.sv
`timescale 1ns / 1ps
// Channel  Signals                         Direction  Moves
// input    in_valid, in_ready, in_data     in         one command request
// output   out_valid, out_ready, out_data  out        one result per request
//
// start_route answers from the idle state, next_stop steps through S_NS_A, S_NS_B and
// S_NS_C, read_next through S_RD, and the block takes no request until its result is taken.
// finish scans the degree balance table node by node (S_BRD, S_BCK), then walks with
// S_WRD and S_WCK per probed neighbor and S_WPOP per pop, probing on the edge table port.
// Reset and clear run a clearing pass over every edge table entry.
// Stalls on the output hold the result register and keep in_ready low.
module eulerian_circuit_finder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ecf_pkg::in_item_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ecf_pkg::out_item_t out_data
);
	import ecf_pkg::*;

	typedef enum logic [10:0] {
		S_CLR  = 11'b00000000001,
		S_IDLE = 11'b00000000010,
		S_NS_A = 11'b00000000100,
		S_NS_B = 11'b00000001000,
		S_NS_C = 11'b00000010000,
		S_BRD  = 11'b00000100000,
		S_BCK  = 11'b00001000000,
		S_WRD  = 11'b00010000000,
		S_WCK  = 11'b00100000000,
		S_WPOP = 11'b01000000000,
		S_RD   = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [EC_AW-1:0]  clr_q;
	logic              clr_resp_q;
	logic [NODE_W-1:0] prev_q, pa_q, na_q, first_q, idx_q, top_q;
	logic              route_open_q, first_valid_q, closed_q, ready_q;
	logic [CNT_W-1:0]  total_q, cl_q, ri_q;
	logic [STK_AW-1:0] sd_q;
	logic              out_valid_q;
	out_item_t         out_q;

	logic              ec_we;
	logic [EC_AW-1:0]  ec_waddr, ec_raddr;
	logic [CNT_W-1:0]  ec_wdata, ec_rdata;
	logic              bal_we;
	logic [NODE_W-1:0] bal_waddr, bal_raddr;
	logic [BAL_W-1:0]  bal_wdata, bal_rdata;
	logic              stk_we;
	logic [STK_AW-1:0] stk_waddr, stk_raddr;
	logic [NODE_W-1:0] stk_wdata, stk_rdata;
	logic              cir_we;
	logic [STK_AW-1:0] cir_waddr, cir_raddr;
	logic [NODE_W-1:0] cir_wdata, cir_rdata;

	logic accept;
	assign in_ready  = (state_q == S_IDLE) && !out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	ecf_ram #(.W(CNT_W), .DEPTH(NODES * NODES)) u_edge_ram (
		.clk(clk), .we(ec_we), .waddr(ec_waddr), .wdata(ec_wdata),
		.raddr(ec_raddr), .rdata(ec_rdata)
	);
	ecf_ram #(.W(BAL_W), .DEPTH(NODES)) u_bal_ram (
		.clk(clk), .we(bal_we), .waddr(bal_waddr), .wdata(bal_wdata),
		.raddr(bal_raddr), .rdata(bal_rdata)
	);
	ecf_ram #(.W(NODE_W), .DEPTH(STK_DEPTH)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);
	ecf_ram #(.W(NODE_W), .DEPTH(STK_DEPTH)) u_circ_ram (
		.clk(clk), .we(cir_we), .waddr(cir_waddr), .wdata(cir_wdata),
		.raddr(cir_raddr), .rdata(cir_rdata)
	);

	// Memory port control.
	always_comb begin
		ec_we     = 1'b0;
		ec_waddr  = {pa_q, na_q};
		ec_wdata  = ec_rdata + CNT_W'(1);
		ec_raddr  = {in_data.stop_node, in_data.stop_node};
		bal_we    = 1'b0;
		bal_waddr = pa_q;
		bal_wdata = bal_rdata + BAL_W'(1);
		bal_raddr = pa_q;
		stk_we    = 1'b0;
		stk_waddr = sd_q;
		stk_wdata = idx_q;
		stk_raddr = sd_q - STK_AW'(2);
		cir_we    = 1'b0;
		cir_waddr = STK_AW'(cl_q);
		cir_wdata = top_q;
		cir_raddr = STK_AW'(cl_q - ri_q - CNT_W'(1));
		unique case (state_q)
			S_CLR: begin
				ec_we     = 1'b1;
				ec_waddr  = clr_q;
				ec_wdata  = '0;
				bal_we    = (clr_q[EC_AW-1:NODE_W] == '0);
				bal_waddr = clr_q[NODE_W-1:0];
				bal_wdata = '0;
			end
			S_IDLE: begin
				ec_raddr = {prev_q, in_data.stop_node};
				bal_raddr = prev_q;
			end
			S_NS_A: begin
				ec_we  = 1'b1;
				bal_we = 1'b1;
			end
			S_NS_B: begin
				bal_raddr = na_q;
			end
			S_NS_C: begin
				bal_we    = 1'b1;
				bal_waddr = na_q;
				bal_wdata = bal_rdata - BAL_W'(1);
			end
			S_BRD: begin
				bal_raddr = idx_q;
			end
			S_BCK: begin
				stk_we    = (bal_rdata == '0) && (idx_q == NODE_W'(NODES - 1));
				stk_waddr = '0;
				stk_wdata = first_q;
			end
			S_WRD: begin
				ec_raddr = {top_q, idx_q};
			end
			S_WCK: begin
				if (ec_rdata != '0) begin
					ec_we    = 1'b1;
					ec_waddr = {top_q, idx_q};
					ec_wdata = ec_rdata - CNT_W'(1);
					stk_we   = 1'b1;
				end else if (idx_q == NODE_W'(NODES - 1)) begin
					cir_we = 1'b1;
				end
			end
			S_WPOP: ;
			S_RD: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLR;
			clr_q         <= '0;
			clr_resp_q    <= 1'b0;
			prev_q        <= '0;
			pa_q          <= '0;
			na_q          <= '0;
			top_q         <= '0;
			route_open_q  <= 1'b0;
			first_q       <= '0;
			first_valid_q <= 1'b0;
			closed_q      <= 1'b0;
			ready_q       <= 1'b0;
			total_q       <= '0;
			cl_q          <= '0;
			ri_q          <= '0;
			sd_q          <= '0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + EC_AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
						if (clr_resp_q) begin
							out_valid_q <= 1'b1;
							out_q       <= '{status: ST_OK, default: '0};
						end
						clr_resp_q <= 1'b0;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (in_data.command)
							CMD_START: begin
								out_valid_q <= 1'b1;
								if (!closed_q) begin
									prev_q       <= in_data.stop_node;
									route_open_q <= 1'b1;
									out_q        <= '{status: ST_OK, default: '0};
								end else begin
									out_q <= '{status: ST_ORDER, default: '0};
								end
							end
							CMD_NEXT: begin
								if (closed_q || !route_open_q) begin
									out_valid_q <= 1'b1;
									out_q       <= '{status: ST_ORDER, default: '0};
								end else if (total_q >= CNT_W'(EDGES)) begin
									out_valid_q <= 1'b1;
									out_q       <= '{status: ST_OVER, default: '0};
								end else begin
									if (!first_valid_q) begin
										first_q       <= prev_q;
										first_valid_q <= 1'b1;
									end
									pa_q    <= prev_q;
									na_q    <= in_data.stop_node;
									prev_q  <= in_data.stop_node;
									total_q <= total_q + CNT_W'(1);
									state_q <= S_NS_A;
								end
							end
							CMD_FINISH: begin
								if (closed_q) begin
									out_valid_q <= 1'b1;
									out_q       <= '{status: ST_ORDER, default: '0};
								end else begin
									closed_q     <= 1'b1;
									route_open_q <= 1'b0;
									out_q        <= '{status: ST_NOCIRC, edge_count: total_q,
										default: '0};
									if (total_q == '0) begin
										out_valid_q <= 1'b1;
									end else begin
										idx_q   <= '0;
										state_q <= S_BRD;
									end
								end
							end
							CMD_READ: begin
								if (!ready_q || ri_q >= cl_q) begin
									out_valid_q <= 1'b1;
									out_q       <= '{status: ST_ORDER, default: '0};
								end else begin
									state_q <= S_RD;
								end
							end
							CMD_CLEAR: begin
								clr_resp_q    <= 1'b1;
								clr_q         <= '0;
								prev_q        <= '0;
								route_open_q  <= 1'b0;
								first_q       <= '0;
								first_valid_q <= 1'b0;
								closed_q      <= 1'b0;
								ready_q       <= 1'b0;
								total_q       <= '0;
								cl_q          <= '0;
								ri_q          <= '0;
								sd_q          <= '0;
								state_q       <= S_CLR;
							end
							default: begin
								out_valid_q <= 1'b1;
								out_q       <= '{status: ST_ORDER, default: '0};
							end
						endcase
					end
				end
				S_NS_A: state_q <= S_NS_B;
				S_NS_B: state_q <= S_NS_C;
				S_NS_C: begin
					out_valid_q <= 1'b1;
					out_q       <= '{status: ST_OK, default: '0};
					state_q     <= S_IDLE;
				end
				S_BRD: state_q <= S_BCK;
				S_BCK: begin
					if (bal_rdata != '0) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end else if (idx_q == NODE_W'(NODES - 1)) begin
						// The first stop of the first loaded edge always has an outgoing edge.
						sd_q    <= STK_AW'(1);
						top_q   <= first_q;
						cl_q    <= '0;
						idx_q   <= '0;
						state_q <= S_WRD;
					end else begin
						idx_q   <= idx_q + NODE_W'(1);
						state_q <= S_BRD;
					end
				end
				S_WRD: state_q <= S_WCK;
				S_WCK: begin
					if (ec_rdata != '0) begin
						sd_q    <= sd_q + STK_AW'(1);
						top_q   <= idx_q;
						idx_q   <= '0;
						state_q <= S_WRD;
					end else if (idx_q == NODE_W'(NODES - 1)) begin
						cl_q  <= cl_q + CNT_W'(1);
						sd_q  <= sd_q - STK_AW'(1);
						idx_q <= '0;
						if (sd_q == STK_AW'(1)) begin
							// Circuit length minus one must match the loaded edge count.
							out_valid_q <= 1'b1;
							state_q     <= S_IDLE;
							if (cl_q == total_q) begin
								out_q.status <= ST_OK;
								ready_q      <= 1'b1;
								ri_q         <= '0;
							end
						end else begin
							state_q <= S_WPOP;
						end
					end else begin
						idx_q   <= idx_q + NODE_W'(1);
						state_q <= S_WRD;
					end
				end
				S_WPOP: begin
					top_q   <= stk_rdata;
					state_q <= S_WRD;
				end
				S_RD: begin
					out_valid_q <= 1'b1;
					out_q       <= '{status: ST_OK, edge_count: '0, circuit_node: cir_rdata,
						last: (ri_q + CNT_W'(1) == cl_q)};
					ri_q        <= ri_q + CNT_W'(1);
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_ready_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid_q)
		else $error("request taken while a result is pending");
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sd_q <= STK_AW'(STK_DEPTH))
		else $error("walk stack exceeded its depth");
	a_circ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cl_q <= CNT_W'(EDGES + 1))
		else $error("circuit length exceeded its limit");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (ready_q && ri_q < cl_q))
		else $error("circuit read past its end");

endmodule
